[design/dhv_pkg.sv]
// Shared types and constants for the detection history validator.
package dhv_pkg;

  localparam int unsigned XW         = 15;
  localparam int unsigned RW         = 13;
  localparam int unsigned ENTRY_W    = 2 * XW + RW;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CONS_W     = 20;
  localparam int unsigned SAME_W     = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned MUL_W      = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned ROOT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CONSISTENCY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_OBJECT = 1'b1;

  localparam logic [CONS_W-1:0] CONS_RESET = 20'd320;
  localparam logic [SAME_W-1:0] SAME_RESET = 16'd160;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [RW-1:0] r;
  } circle_t;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_R
  } comp_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRITE,
    ST_LIMSQ,
    ST_LIMST,
    ST_CH_RD,
    ST_CH_LD,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SQRT,
    ST_GRP_INIT,
    ST_SEED,
    ST_SEED_LD,
    ST_PAIR,
    ST_PAIR_LD,
    ST_CMP,
    ST_GRP_END,
    ST_DIV,
    ST_SNEXT,
    ST_DONE
  } state_e;

endpackage

[design/dhv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module dhv_ram #(
  parameter int unsigned WIDTH = 43,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/detection_history_validator.sv]
// Top level of the detection history validator: ring history, chain check and grouping.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_ready_o  found_i, centre_x_i, centre_y_i, radius_i
//   out      out_valid_o/ out_ready_i steady_*, history_full_o, likely_*
//   cfg      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One beat runs through a sequencer around one shared 16x16 multiplier, a bit-serial square
// root and a bit-serial divider (one quotient bit per cycle). The chain check sums the
// distances over WINDOW entries; once the ring has wrapped, grouping follows, and each new
// best group is averaged by the divider.
// Reset clears the history through per-slot valid bits at once; no clearing pass is needed.
// The input is not ready while a beat is in work; a finished result waits in the output
// register and the next input beat is taken while it waits.
module detection_history_validator #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned WINDOW        = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dhv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dhv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             found_i,
  input  logic [dhv_pkg::XW-1:0]           centre_x_i,
  input  logic [dhv_pkg::XW-1:0]           centre_y_i,
  input  logic [dhv_pkg::RW-1:0]           radius_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             steady_valid_o,
  output logic [dhv_pkg::XW-1:0]           steady_x_o,
  output logic [dhv_pkg::XW-1:0]           steady_y_o,
  output logic [dhv_pkg::RW-1:0]           steady_r_o,
  output logic                             history_full_o,
  output logic [dhv_pkg::XW-1:0]           likely_x_o,
  output logic [dhv_pkg::XW-1:0]           likely_y_o,
  output logic [dhv_pkg::RW-1:0]           likely_r_o,
  output logic [dhv_pkg::COUNT_W-1:0]      likely_count_o
);

  localparam int unsigned IW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = dhv_pkg::XW + CNT_W;
  localparam int unsigned DCW   = $clog2(SUM_W);
  localparam int unsigned WCW   = $clog2(WINDOW + 1);
  localparam int unsigned CSW   = dhv_pkg::ROOT_W + $clog2(WINDOW + 1);

  dhv_pkg::state_e state_q, state_d;

  logic [dhv_pkg::CONS_W-1:0] cons_q;
  logic [dhv_pkg::SAME_W-1:0] same_q;
  logic [IW-1:0]              slot_q;
  logic                       primed_q, wrapped_q;
  logic [HISTORY_DEPTH-1:0]   valid_q;
  logic                       out_vld_q;

  dhv_pkg::circle_t new_q, a_q, b_q, rd_circ;
  logic [IW-1:0]              cur_q, seed_q, j_q, next_slot, cur_prev;
  logic [WCW-1:0]             win_q;
  logic [CSW-1:0]             csum_q;
  logic [dhv_pkg::SQ_W-1:0]   prod_q, acc_q, limsq_q;
  logic [dhv_pkg::SQ_W-1:0]   srem_q, sres_q, sbit_q, strial, srem_d, sres_d;
  logic                       grp_q;
  logic [HISTORY_DEPTH-1:0]   taken_q;
  logic [CNT_W-1:0]           cnt_q, best_q;
  logic [SUM_W-1:0]           sx_q, sy_q, sr_q, num_q, num_d;
  logic [CNT_W-1:0]           drem_q, drem_d;
  logic [CNT_W:0]             dtrial, ddiff;
  logic                       dge;
  logic [DCW-1:0]             dcnt_q;
  dhv_pkg::comp_e             comp_q;
  logic [dhv_pkg::XW-1:0]     lx_q, ly_q;
  logic [dhv_pkg::RW-1:0]     lr_q;
  logic                       rd_vld_q;
  logic [dhv_pkg::ENTRY_W-1:0] rd_data;

  logic                       ram_we;
  logic [IW-1:0]              ram_raddr;
  logic [dhv_pkg::MUL_W-1:0]  mul_a;
  logic [dhv_pkg::SQ_W-1:0]   mul_p;
  logic                       in_acc, sqrt_last, div_last, in_range;

  logic                       o_steady_q, o_full_q;
  dhv_pkg::circle_t           o_steady_c_q, o_likely_c_q;
  logic [dhv_pkg::COUNT_W-1:0] o_count_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == dhv_pkg::ST_IDLE);
  assign next_slot = (slot_q == IW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign cur_prev  = (cur_q == '0) ? IW'(HISTORY_DEPTH - 1) : cur_q - 1'b1;
  assign rd_circ   = rd_vld_q ? dhv_pkg::circle_t'(rd_data) : '0;
  assign sqrt_last = sbit_q[0];
  assign div_last  = (dcnt_q == DCW'(SUM_W - 1));
  assign in_range  = (acc_q < limsq_q);

  dhv_ram #(
    .WIDTH(dhv_pkg::ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_slot),
    .wdata_i(new_q),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  // Shared multiplier operand, history write enable and history read address.
  always_comb begin
    mul_a     = '0;
    ram_we    = 1'b0;
    ram_raddr = cur_prev;
    case (state_q)
      dhv_pkg::ST_WRITE:  ram_we = 1'b1;
      dhv_pkg::ST_LIMSQ:  mul_a = same_q;
      dhv_pkg::ST_SQ0: begin
        mul_a = {1'b0, (a_q.x > b_q.x) ? a_q.x - b_q.x : b_q.x - a_q.x};
      end
      dhv_pkg::ST_SQ1: begin
        mul_a = {1'b0, (a_q.y > b_q.y) ? a_q.y - b_q.y : b_q.y - a_q.y};
      end
      dhv_pkg::ST_SQ2: begin
        mul_a = {3'b0, (a_q.r > b_q.r) ? a_q.r - b_q.r : b_q.r - a_q.r};
      end
      dhv_pkg::ST_SEED:   ram_raddr = seed_q;
      dhv_pkg::ST_PAIR:   ram_raddr = j_q;
      default:            ram_raddr = cur_prev;
    endcase
  end

  assign mul_p = dhv_pkg::SQ_W'(mul_a) * dhv_pkg::SQ_W'(mul_a);

  assign strial = sres_q + sbit_q;
  always_comb begin
    if (srem_q >= strial) begin
      srem_d = srem_q - strial;
      sres_d = (sres_q >> 1) + sbit_q;
    end else begin
      srem_d = srem_q;
      sres_d = sres_q >> 1;
    end
  end

  assign dtrial = {drem_q, num_q[SUM_W-1]};
  assign dge    = (dtrial >= {1'b0, cnt_q});
  assign ddiff  = dtrial - {1'b0, cnt_q};
  assign drem_d = dge ? ddiff[CNT_W-1:0] : dtrial[CNT_W-1:0];
  assign num_d  = {num_q[SUM_W-2:0], dge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      dhv_pkg::ST_IDLE:     if (in_valid_i) state_d = dhv_pkg::ST_WRITE;
      dhv_pkg::ST_WRITE:    state_d = dhv_pkg::ST_LIMSQ;
      dhv_pkg::ST_LIMSQ:    state_d = dhv_pkg::ST_LIMST;
      dhv_pkg::ST_LIMST:    state_d = dhv_pkg::ST_CH_RD;
      dhv_pkg::ST_CH_RD:    state_d = dhv_pkg::ST_CH_LD;
      dhv_pkg::ST_CH_LD:    state_d = dhv_pkg::ST_SQ0;
      dhv_pkg::ST_SQ0:      state_d = dhv_pkg::ST_SQ1;
      dhv_pkg::ST_SQ1:      state_d = dhv_pkg::ST_SQ2;
      dhv_pkg::ST_SQ2:      state_d = grp_q ? dhv_pkg::ST_SQ3 : dhv_pkg::ST_SQRT;
      dhv_pkg::ST_SQ3:      state_d = dhv_pkg::ST_CMP;
      dhv_pkg::ST_SQRT: begin
        if (sqrt_last) begin
          if (win_q != WCW'(WINDOW - 1)) begin
            state_d = dhv_pkg::ST_CH_RD;
          end else if (wrapped_q) begin
            state_d = dhv_pkg::ST_GRP_INIT;
          end else begin
            state_d = dhv_pkg::ST_DONE;
          end
        end
      end
      dhv_pkg::ST_GRP_INIT: state_d = dhv_pkg::ST_SEED;
      dhv_pkg::ST_SEED: begin
        state_d = taken_q[seed_q] ? dhv_pkg::ST_SNEXT : dhv_pkg::ST_SEED_LD;
      end
      dhv_pkg::ST_SEED_LD:  state_d = dhv_pkg::ST_PAIR;
      dhv_pkg::ST_PAIR: begin
        if (j_q == seed_q) begin
          state_d = dhv_pkg::ST_GRP_END;
        end else if (!taken_q[j_q]) begin
          state_d = dhv_pkg::ST_PAIR_LD;
        end
      end
      dhv_pkg::ST_PAIR_LD:  state_d = dhv_pkg::ST_SQ0;
      dhv_pkg::ST_CMP:      state_d = dhv_pkg::ST_PAIR;
      dhv_pkg::ST_GRP_END:  state_d = (cnt_q > best_q) ? dhv_pkg::ST_DIV : dhv_pkg::ST_SNEXT;
      dhv_pkg::ST_DIV: begin
        if (div_last && comp_q == dhv_pkg::COMP_R) state_d = dhv_pkg::ST_SNEXT;
      end
      dhv_pkg::ST_SNEXT:    state_d = (seed_q == '0) ? dhv_pkg::ST_DONE : dhv_pkg::ST_SEED;
      dhv_pkg::ST_DONE:     if (!out_vld_q || out_ready_i) state_d = dhv_pkg::ST_IDLE;
      default:              state_d = dhv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dhv_pkg::ST_IDLE;
      cons_q    <= dhv_pkg::CONS_RESET;
      same_q    <= dhv_pkg::SAME_RESET;
      slot_q    <= IW'(HISTORY_DEPTH - 1);
      primed_q  <= 1'b0;
      wrapped_q <= 1'b0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == dhv_pkg::REG_CONSISTENCY) begin
          cons_q <= cfg_data_i[dhv_pkg::CONS_W-1:0];
        end else if (cfg_idx_i == dhv_pkg::REG_SAME_OBJECT) begin
          same_q <= cfg_data_i[dhv_pkg::SAME_W-1:0];
        end
      end
      if (state_q == dhv_pkg::ST_WRITE) begin
        slot_q             <= next_slot;
        primed_q           <= 1'b1;
        valid_q[next_slot] <= 1'b1;
        if (slot_q == IW'(HISTORY_DEPTH - 1) && primed_q) begin
          wrapped_q <= 1'b1;
        end
      end
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == dhv_pkg::ST_DONE && state_d == dhv_pkg::ST_IDLE) begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= valid_q[ram_raddr];
    prod_q   <= mul_p;
    case (state_q)
      dhv_pkg::ST_IDLE: begin
        if (in_acc) begin
          new_q.x <= found_i ? centre_x_i : '0;
          new_q.y <= found_i ? centre_y_i : '0;
          new_q.r <= found_i ? radius_i : '0;
        end
      end
      dhv_pkg::ST_WRITE: begin
        a_q    <= new_q;
        cur_q  <= next_slot;
        win_q  <= '0;
        csum_q <= '0;
        grp_q  <= 1'b0;
        best_q <= '0;
        lx_q   <= '0;
        ly_q   <= '0;
        lr_q   <= '0;
      end
      dhv_pkg::ST_LIMST:  limsq_q <= prod_q;
      dhv_pkg::ST_CH_RD:  cur_q <= cur_prev;
      dhv_pkg::ST_CH_LD:  b_q <= rd_circ;
      dhv_pkg::ST_SQ1:    acc_q <= prod_q;
      dhv_pkg::ST_SQ2: begin
        acc_q  <= acc_q + prod_q;
        srem_q <= acc_q + prod_q;
        sres_q <= '0;
        sbit_q <= 32'h4000_0000;
      end
      dhv_pkg::ST_SQ3:    acc_q <= acc_q + prod_q;
      dhv_pkg::ST_SQRT: begin
        srem_q <= srem_d;
        sres_q <= sres_d;
        sbit_q <= sbit_q >> 2;
        if (sqrt_last) begin
          csum_q <= csum_q + CSW'(sres_d[dhv_pkg::ROOT_W-1:0]);
          a_q    <= b_q;
          win_q  <= win_q + 1'b1;
        end
      end
      dhv_pkg::ST_GRP_INIT: begin
        taken_q <= '0;
        seed_q  <= IW'(HISTORY_DEPTH - 1);
        grp_q   <= 1'b1;
      end
      dhv_pkg::ST_SEED: begin
        if (!taken_q[seed_q]) taken_q[seed_q] <= 1'b1;
      end
      dhv_pkg::ST_SEED_LD: begin
        a_q   <= rd_circ;
        sx_q  <= SUM_W'(rd_circ.x);
        sy_q  <= SUM_W'(rd_circ.y);
        sr_q  <= SUM_W'(rd_circ.r);
        cnt_q <= CNT_W'(1);
        j_q   <= '0;
      end
      dhv_pkg::ST_PAIR: begin
        if (j_q != seed_q && taken_q[j_q]) j_q <= j_q + 1'b1;
      end
      dhv_pkg::ST_PAIR_LD: b_q <= rd_circ;
      dhv_pkg::ST_CMP: begin
        if (in_range) begin
          taken_q[j_q] <= 1'b1;
          cnt_q        <= cnt_q + 1'b1;
          sx_q         <= sx_q + SUM_W'(b_q.x);
          sy_q         <= sy_q + SUM_W'(b_q.y);
          sr_q         <= sr_q + SUM_W'(b_q.r);
        end
        j_q <= j_q + 1'b1;
      end
      dhv_pkg::ST_GRP_END: begin
        if (cnt_q > best_q) begin
          best_q <= cnt_q;
          comp_q <= dhv_pkg::COMP_X;
          num_q  <= sx_q;
          drem_q <= '0;
          dcnt_q <= '0;
        end
      end
      dhv_pkg::ST_DIV: begin
        num_q  <= num_d;
        drem_q <= drem_d;
        dcnt_q <= dcnt_q + 1'b1;
        if (div_last) begin
          drem_q <= '0;
          dcnt_q <= '0;
          case (comp_q)
            dhv_pkg::COMP_X: begin
              lx_q   <= num_d[dhv_pkg::XW-1:0];
              num_q  <= sy_q;
              comp_q <= dhv_pkg::COMP_Y;
            end
            dhv_pkg::COMP_Y: begin
              ly_q   <= num_d[dhv_pkg::XW-1:0];
              num_q  <= sr_q;
              comp_q <= dhv_pkg::COMP_R;
            end
            default: lr_q <= num_d[dhv_pkg::RW-1:0];
          endcase
        end
      end
      dhv_pkg::ST_SNEXT: seed_q <= seed_q - 1'b1;
      dhv_pkg::ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          o_steady_q   <= (32'(csum_q) < 32'(cons_q));
          o_steady_c_q <= (32'(csum_q) < 32'(cons_q)) ? new_q : '0;
          o_full_q     <= wrapped_q;
          o_likely_c_q <= '{x: lx_q, y: ly_q, r: lr_q};
          o_count_q    <= dhv_pkg::COUNT_W'(best_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_vld_q;
  assign steady_valid_o = o_steady_q;
  assign steady_x_o     = o_steady_c_q.x;
  assign steady_y_o     = o_steady_c_q.y;
  assign steady_r_o     = o_steady_c_q.r;
  assign history_full_o = o_full_q;
  assign likely_x_o     = o_likely_c_q.x;
  assign likely_y_o     = o_likely_c_q.y;
  assign likely_r_o     = o_likely_c_q.r;
  assign likely_count_o = o_count_q;

endmodule
